/* design/rgb_hsl_color_convert_top_defines.svh */
// ----------------------------------------------------------------------------
// RGB/HSL converter assertion macros
// Shared property forms for the concurrent checks of the converter.
// ----------------------------------------------------------------------------
`ifndef RGB_HSL_COLOR_CONVERT_TOP_DEFINES_SVH
`define RGB_HSL_COLOR_CONVERT_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RHCC_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RHCC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* design/rhcc_pkg.sv */
// ----------------------------------------------------------------------------
// RGB/HSL converter package
// Command codes, fixed-point scale constants, divider sizing and the hue ramp.
// ----------------------------------------------------------------------------
package rhcc_pkg;

  // Operation selector carried with each input transaction.
  typedef enum logic [1:0] {
    CMD_TO_HSL = 2'd0,
    CMD_TO_RGB = 2'd1,
    CMD_ROTATE = 2'd2
  } cmd_e;

  // Saturation and lightness scale: 25600 is 100 percent.
  localparam logic [14:0] FULL_SCALE = 15'd25600;
  localparam logic [14:0] HALF_SCALE = 15'd12800;

  // Divider sizing. Both dividers must end up with the same stage count.
  localparam int unsigned DIV_DW  = 8;
  localparam int unsigned SAT_QW  = 15;
  localparam int unsigned SAT_SPS = 3;
  localparam int unsigned HUE_QW  = 10;
  localparam int unsigned HUE_SPS = 2;

  // Weight of the m2 - m1 term for a channel angle t in 0..360 degrees.
  function automatic logic [5:0] ramp_pos(input logic [8:0] t);
    logic [5:0] r;
    if (t < 9'd60) begin
      r = t[5:0];
    end else if (t < 9'd180) begin
      r = 6'd60;
    end else if (t < 9'd240) begin
      r = 6'(9'd240 - t);
    end else begin
      r = 6'd0;
    end
    return r;
  endfunction

endpackage

/* design/rhcc_div.sv */
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Unsigned division, SPS quotient bits per register stage. The top DW bits
// of the numerator must be below the divisor.
// ----------------------------------------------------------------------------
module rhcc_div #(
  parameter int unsigned DW  = rhcc_pkg::DIV_DW,
  parameter int unsigned QW  = rhcc_pkg::SAT_QW,
  parameter int unsigned SPS = rhcc_pkg::SAT_SPS
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [DW+QW-1:0] num_i,
  input  logic [DW-1:0]    den_i,
  output logic [QW-1:0]    quot_o,
  output logic [DW-1:0]    rem_o
);

  localparam int unsigned NW     = DW + QW;
  localparam int unsigned STAGES = QW / SPS;

  logic [NW-1:0] acc_q [STAGES];
  logic [DW-1:0] den_q [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [NW-1:0] acc_in;
    logic [NW-1:0] acc_d;
    logic [DW-1:0] den_in;

    if (s == 0) begin : g_first
      assign acc_in = num_i;
      assign den_in = den_i;
    end else begin : g_next
      assign acc_in = acc_q[s-1];
      assign den_in = den_q[s-1];
    end

    // Shift in one numerator bit, subtract when it fits, shift in the quotient bit.
    always_comb begin
      logic [DW:0] trial;
      logic        qbit;
      acc_d = acc_in;
      trial = '0;
      qbit  = 1'b0;
      for (int k = 0; k < int'(SPS); k++) begin
        trial = acc_d[NW-1:QW-1];
        qbit  = (trial >= {1'b0, den_in});
        if (qbit) begin
          trial = trial - {1'b0, den_in};
        end
        acc_d = {trial[DW-1:0], acc_d[QW-2:0], qbit};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[s] <= acc_d;
        den_q[s] <= den_in;
      end
    end
  end

  assign quot_o = acc_q[STAGES-1][QW-1:0];
  assign rem_o  = acc_q[STAGES-1][NW-1:QW];

endmodule

/* design/rgb_hsl_color_convert_top.sv */
// ----------------------------------------------------------------------------
// RGB/HSL color converter
// Converts RGB to HSL, HSL to RGB, or rotates the hue of an RGB color.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock while the output is not stalled.
// Each transaction passes through fourteen register stages, the first of which
// loads on the accepting edge. The stages are one of channel sorting, five of
// the restoring dividers for saturation and hue, and eight of hue wrapping and
// fixed-point multiply and scale for the RGB channels. A stall on the output
// holds the whole pipeline; nothing is dropped or repeated.
`include "rgb_hsl_color_convert_top_defines.svh"

module rgb_hsl_color_convert_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // red_in[7:0], green_in[15:8], blue_in[23:16], hue_in[39:24],
  // sat_in[55:40], light_in[71:56], hue_shift[87:72]
  input  logic [87:0] s_axis_tdata,
  // cmd[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // red_out[7:0], green_out[15:8], blue_out[23:16], hue_out[32:24],
  // sat_out[47:33], light_out[62:48], zero[63]
  output logic [63:0] m_axis_tdata
);

  localparam int unsigned LAT        = 14;
  localparam int unsigned DIV_STAGES = rhcc_pkg::SAT_QW / rhcc_pkg::SAT_SPS;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        d_zero;
    logic        hue_neg;
    logic [8:0]  hue_base;
    logic [14:0] s_cl;
    logic [14:0] l_cl;
    logic [15:0] hadd;
    logic [14:0] lum;
  } meta_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [8:0]  hue;
    logic [14:0] sat;
    logic [14:0] lum;
  } ometa_t;

  function automatic logic [14:0] clamp_pct(input logic signed [15:0] x);
    logic [14:0] r;
    if (x < 16'sd0) begin
      r = '0;
    end else if (x > 16'sd25600) begin
      r = rhcc_pkg::FULL_SCALE;
    end else begin
      r = x[14:0];
    end
    return r;
  endfunction

  // Pipeline flow control: every stage moves when the output can move.
  logic           adv;
  logic [LAT-1:0] vld_q;

  assign adv           = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  // Input fields.
  logic [1:0]         in_cmd;
  logic [7:0]         in_red, in_green, in_blue;
  logic signed [15:0] in_hue, in_sat, in_light, in_shift;

  assign in_cmd   = s_axis_tuser[1:0];
  assign in_red   = s_axis_tdata[7:0];
  assign in_green = s_axis_tdata[15:8];
  assign in_blue  = s_axis_tdata[23:16];
  assign in_hue   = s_axis_tdata[39:24];
  assign in_sat   = s_axis_tdata[55:40];
  assign in_light = s_axis_tdata[71:56];
  assign in_shift = s_axis_tdata[87:72];

  // Stage 1: sort the channels and form the divider operands.
  logic [7:0]  mx, mn, dlt, den, adiff;
  logic [8:0]  sum;
  logic        hneg;
  logic [8:0]  hbase;
  meta_t       m1_d;
  logic [22:0] snum_d, ly_d;
  logic [17:0] hnum_d;

  always_comb begin
    mx = in_red;
    if (in_green > mx) mx = in_green;
    if (in_blue > mx) mx = in_blue;
    mn = in_red;
    if (in_green < mn) mn = in_green;
    if (in_blue < mn) mn = in_blue;
    dlt = mx - mn;
    sum = {1'b0, mx} + {1'b0, mn};
    den = (sum < 9'd255) ? sum[7:0] : 8'(9'd510 - sum);
    if (in_red == mx) begin
      hneg  = in_green < in_blue;
      adiff = hneg ? in_blue - in_green : in_green - in_blue;
      hbase = hneg ? 9'd360 : 9'd0;
    end else if (in_green == mx) begin
      hneg  = in_blue < in_red;
      adiff = hneg ? in_red - in_blue : in_blue - in_red;
      hbase = 9'd120;
    end else begin
      hneg  = in_red < in_green;
      adiff = hneg ? in_green - in_red : in_red - in_green;
      hbase = 9'd240;
    end
    snum_d = 23'(dlt) * 23'd25600 + 23'(den >> 1);
    hnum_d = 18'(adiff) * 18'd60;
    ly_d   = 23'((24'(sum) * 24'd25600 + 24'd255) >> 1);
    m1_d.cmd      = in_cmd;
    m1_d.d_zero   = (dlt == 8'd0);
    m1_d.hue_neg  = hneg;
    m1_d.hue_base = hbase;
    m1_d.s_cl     = clamp_pct(in_sat);
    m1_d.l_cl     = clamp_pct(in_light);
    m1_d.hadd     = (in_cmd == rhcc_pkg::CMD_ROTATE) ? in_shift : in_hue;
    m1_d.lum      = '0;
  end

  // Hue divisor is the channel spread, kept beside the other first-stage operands.
  meta_t       m1_q;
  logic [7:0]  den1_q;
  logic [7:0]  dlt1_q;
  logic [22:0] snum1_q, ly1_q;
  logic [17:0] hnum1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_q    <= m1_d;
      den1_q  <= den;
      dlt1_q  <= dlt;
      snum1_q <= snum_d;
      hnum1_q <= hnum_d;
      ly1_q   <= ly_d;
    end
  end

  // Stages 2 to 6: saturation and hue dividers run side by side.
  logic [rhcc_pkg::SAT_QW-1:0] sat_quot;
  logic [rhcc_pkg::HUE_QW-1:0] hue_quot;
  logic [rhcc_pkg::DIV_DW-1:0] hue_rem;

  rhcc_div #(
    .DW (rhcc_pkg::DIV_DW),
    .QW (rhcc_pkg::SAT_QW),
    .SPS(rhcc_pkg::SAT_SPS)
  ) u_sat_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (snum1_q),
    .den_i (den1_q),
    .quot_o(sat_quot),
    .rem_o ()
  );

  rhcc_div #(
    .DW (rhcc_pkg::DIV_DW),
    .QW (rhcc_pkg::HUE_QW),
    .SPS(rhcc_pkg::HUE_SPS)
  ) u_hue_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (hnum1_q),
    .den_i (dlt1_q),
    .quot_o(hue_quot),
    .rem_o (hue_rem)
  );

  // Lightness: divide by 255 with a reciprocal multiply, beside the dividers.
  logic [46:0] lprod_q;
  meta_t       mq [DIV_STAGES];
  meta_t       mfix;

  always_comb begin
    mfix     = mq[0];
    mfix.lum = lprod_q[45:31];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lprod_q <= 47'(ly1_q) * 47'd8421505;
      mq[0]   <= m1_q;
      for (int k = 1; k < int'(DIV_STAGES); k++) begin
        mq[k] <= (k == 1) ? mfix : mq[k-1];
      end
    end
  end

  // Stage 7: finish hue and saturation, pick the HSL source, offset the hue.
  meta_t              mt;
  logic [9:0]         hoff;
  logic [8:0]         hue_v;
  logic [14:0]        sat_v;
  logic signed [16:0] hsum;
  logic               rot;
  ometa_t             o7_d;
  logic [16:0]        y7_d;
  logic [14:0]        s7_d, l7_d;

  always_comb begin
    mt    = mq[DIV_STAGES-1];
    rot   = (mt.cmd == rhcc_pkg::CMD_ROTATE);
    hoff  = hue_quot + 10'(hue_rem != '0);
    if (mt.d_zero) begin
      hue_v = '0;
    end else if (mt.hue_neg) begin
      hue_v = mt.hue_base - hoff[8:0];
    end else begin
      hue_v = mt.hue_base + hue_quot[8:0];
    end
    sat_v    = mt.d_zero ? 15'd0 : sat_quot;
    hsum     = (rot ? signed'(17'(hue_v)) : 17'sd0) + signed'({mt.hadd[15], mt.hadd});
    y7_d     = 17'(hsum) + 17'd33120;
    s7_d     = rot ? sat_v : mt.s_cl;
    l7_d     = rot ? mt.lum : mt.l_cl;
    o7_d.cmd = mt.cmd;
    o7_d.hue = hue_v;
    o7_d.sat = sat_v;
    o7_d.lum = mt.lum;
  end

  ometa_t      o7_q;
  logic [16:0] y7_q;
  logic [14:0] s7_q, l7_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      o7_q <= o7_d;
      y7_q <= y7_d;
      s7_q <= s7_d;
      l7_q <= l7_d;
    end
  end

  // Stage 8: quotient estimate for the hue wrap and the S times L product.
  ometa_t      oq [6];
  logic [33:0] qm8_q;
  logic [29:0] ls8_q;
  logic [16:0] y8_q;
  logic [14:0] s8_q, l8_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      oq[0] <= o7_q;
      for (int k = 1; k < 6; k++) begin
        oq[k] <= oq[k-1];
      end
      qm8_q <= 34'(y7_q) * 34'd93207;
      ls8_q <= 30'(s7_q) * 30'(l7_q);
      y8_q  <= y7_q;
      s8_q  <= s7_q;
      l8_q  <= l7_q;
    end
  end

  // Stage 9: hue modulo 360 and the upper level m2.
  logic [8:0]  q9;
  logic [16:0] hw9;
  logic [30:0] ld9, sd9, m2_9;

  always_comb begin
    q9  = qm8_q[33:25];
    hw9 = y8_q - 17'(q9) * 17'd360;
    ld9 = 31'(l8_q) * 31'd25600;
    sd9 = 31'(s8_q) * 31'd25600;
    if (l8_q <= rhcc_pkg::HALF_SCALE) begin
      m2_9 = 31'(ls8_q) + ld9;
    end else begin
      m2_9 = ld9 + sd9 - 31'(ls8_q);
    end
  end

  logic [8:0]  h9_q;
  logic [29:0] m2_9_q, ld9_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      h9_q   <= hw9[8:0];
      m2_9_q <= m2_9[29:0];
      ld9_q  <= ld9[29:0];
    end
  end

  // Stage 10: lower level m1, the span, and each channel's ramp weight.
  logic [30:0] m1_10;
  logic [29:0] dm10;
  logic [8:0]  t10 [3];

  always_comb begin
    m1_10  = {ld9_q, 1'b0} - 31'(m2_9_q);
    dm10   = m2_9_q - m1_10[29:0];
    t10[0] = (h9_q >= 9'd241) ? h9_q - 9'd240 : h9_q + 9'd120;
    t10[1] = h9_q;
    t10[2] = (h9_q < 9'd120) ? h9_q + 9'd240 : h9_q - 9'd120;
  end

  logic [29:0] m1_10_q, dm10_q;
  logic [5:0]  tp10_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_10_q <= m1_10[29:0];
      dm10_q  <= dm10;
      for (int c = 0; c < 3; c++) begin
        tp10_q[c] <= rhcc_pkg::ramp_pos(t10[c]);
      end
    end
  end

  // Stages 11 to 13: channel level, scale to 8 bits, divide by the constant.
  logic [35:0] w11_q [3];
  logic [21:0] y12_q [3];
  logic [44:0] p13_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        w11_q[c] <= 36'(m1_10_q) * 36'd60 + 36'(dm10_q) * 36'(tp10_q[c]);
        y12_q[c] <= 22'((44'(w11_q[c]) * 44'd255 + 44'd19660800000) >> 22);
        p13_q[c] <= 45'(y12_q[c]) * 45'd7330078;
      end
    end
  end

  // Stage 14: saturate the channels and select the fields for the command.
  logic [7:0]  chan [3];
  ometa_t      ot;
  logic [7:0]  red_d, green_d, blue_d;
  logic [8:0]  hue_d;
  logic [14:0] sat_d, lum_d;

  always_comb begin
    ot = oq[5];
    for (int c = 0; c < 3; c++) begin
      chan[c] = p13_q[c][44] ? 8'd255 : p13_q[c][43:36];
    end
    red_d   = '0;
    green_d = '0;
    blue_d  = '0;
    hue_d   = '0;
    sat_d   = '0;
    lum_d   = '0;
    case (ot.cmd)
      rhcc_pkg::CMD_TO_HSL: begin
        hue_d = ot.hue;
        sat_d = ot.sat;
        lum_d = ot.lum;
      end
      rhcc_pkg::CMD_TO_RGB, rhcc_pkg::CMD_ROTATE: begin
        red_d   = chan[0];
        green_d = chan[1];
        blue_d  = chan[2];
      end
      default: begin
        red_d = '0;
      end
    endcase
  end

  logic [7:0]  red_q, green_q, blue_q;
  logic [8:0]  hue_q;
  logic [14:0] sat_q, lum_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
      hue_q   <= hue_d;
      sat_q   <= sat_d;
      lum_q   <= lum_d;
    end
  end

  assign m_axis_tdata = {1'b0, lum_q, sat_q, hue_q, blue_q, green_q, red_q};

  // Checks.
  `RHCC_ASSERT_NEXT(a_stall_holds_valid, !adv, $stable(vld_q),
                    "pipeline valid bits moved during a stall")
  `RHCC_ASSERT_NOW(a_one_result_kind,
                   m_axis_tvalid && (hue_q != '0 || sat_q != '0 || lum_q != '0),
                   red_q == '0 && green_q == '0 && blue_q == '0,
                   "result carries both HSL and RGB fields")
  `RHCC_ASSERT_NOW(a_hsl_range, m_axis_tvalid,
                   hue_q <= 9'd359 && sat_q <= rhcc_pkg::FULL_SCALE &&
                   lum_q <= rhcc_pkg::FULL_SCALE,
                   "HSL result out of range")

endmodule
